// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl of the circular queue
// simulation gets the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define CQS_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CQS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CQS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CQS_ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define CQS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define CQS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/cqs_pkg.sv -----
// shared types and constants of the circular queue with search
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cqs_pkg;

  // default queue depth
  parameter int unsigned Depth = 16;

  // field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned QsizeW  = 5;

  // queue_size after reset
  localparam logic [QsizeW-1:0] QsizeRst = 5'd16;

  // operation codes
  localparam logic [OpW-1:0] OpEnq  = 2'd0;
  localparam logic [OpW-1:0] OpDeq  = 2'd1;
  localparam logic [OpW-1:0] OpSrch = 2'd2;
  localparam logic [OpW-1:0] OpDisp = 2'd3;

  // result status codes
  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatFull     = 3'd1,
    StatEmpty    = 3'd2,
    StatFound    = 3'd3,
    StatNotFound = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/cqs_in_if.sv -----
// input channel of the circular queue: valid/ready plus operation and value
// depends on cqs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cqs_in_if;
  logic                                valid;
  logic                                ready;
  logic        [cqs_pkg::OpW-1:0]      operation;
  logic signed [cqs_pkg::WordW-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/cqs_out_if.sv -----
// result channel of the circular queue: valid/ready plus status, value_res, last
// depends on cqs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cqs_out_if;
  logic                                valid;
  logic                                ready;
  cqs_pkg::status_e                    status;
  logic signed [cqs_pkg::WordW-1:0]    value_res;
  logic                                last;

  modport source (output valid, output status, output value_res, output last,
                  input ready);
  modport sink   (input valid, input status, input value_res, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/cqs_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/cqs_cmp.sv -----
// shared compare unit of the search walk: holds the search key
// depends on cqs_pkg
`timescale 1ns / 1ps
`default_nettype none

module cqs_cmp (
  input  wire logic                      clk_i,
  input  wire logic                      key_load_i,
  input  wire logic [cqs_pkg::WordW-1:0] key_i,
  input  wire logic [cqs_pkg::WordW-1:0] word_i,
  output      logic                      hit_o
);

  logic [cqs_pkg::WordW-1:0] key_q;

  // key captured when a search item is taken
  always_ff @(posedge clk_i) begin
    if (key_load_i) begin
      key_q <= key_i;
    end
  end

  // one word compared per cycle
  assign hit_o = (word_i == key_q);

endmodule

`default_nettype wire

// ----- rtl/circular_queue_with_search.sv -----
// Circular FIFO of signed 32-bit words with search and display walks.
// Channels: in_i (operation, value) and out_o (status, value_res, last),
// both valid/ready; an item moves at a clock edge with valid and ready high.
// cfg_we_i/cfg_wdata_i write queue_size (capacity, 0 acts as 1, clipped to
// DEPTH); write it only while the block is idle.
// Steps from the accepting edge: an enqueue, or any item on an empty queue,
// loads its result straight into the result register; a dequeue first reads
// the head word from the ram in S_DEQ; a search compares in S_SRCH up to a hit
// or the last entry; a display emits one result per cycle from S_DISP while the
// receiver takes them. The next item is taken once the last result is loaded
// and the result register frees.
// The walks are paced by the single read port of the entry ram and one
// shared compare unit: one stored entry is visited per cycle, unless the receiver holds a display walk.
// in_i.ready is high only when no item is in flight and the result register
// is free or being emptied, so one item is worked on at a time.
// A stalled receiver holds the result register; a display walk pauses on
// the current entry until it is taken.
// Reset (rst_ni low, asynchronous) empties the queue and sets queue_size to
// 16; ram contents are not cleared, no clearing pass is needed.
// Depends on cqs_pkg, cqs_in_if, cqs_out_if, cqs_ram, cqs_cmp, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module circular_queue_with_search #(
  parameter int unsigned DEPTH = cqs_pkg::Depth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cqs_pkg::QsizeW-1:0] cfg_wdata_i,
  cqs_in_if.sink                          in_i,
  cqs_out_if.source                       out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = cqs_pkg::WordW;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DISP = 2'd3;

  function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [1:0]                  state_q, state_d;
  logic [AW-1:0]               head_q, head_d;
  logic [AW-1:0]               tail_q, tail_d;
  logic [AW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               occ_q, occ_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [cqs_pkg::QsizeW-1:0]  qsize_q;
  logic                        out_valid_q, out_valid_d;
  cqs_pkg::status_e            out_status_q, out_status_d;
  logic [WW-1:0]               out_value_q, out_value_d;
  logic                        out_last_q, out_last_d;

  logic                        accept;
  logic                        out_free;
  logic                        out_load;
  logic [CW-1:0]               cap;
  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  logic [WW-1:0]               rd_data;
  logic                        key_load;
  logic                        hit;
  logic                        walk_end;

  // effective capacity from queue_size
  always_comb begin
    if (qsize_q == '0) begin
      cap = CW'(1);
    end else if (32'(qsize_q) > 32'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(qsize_q);
    end
  end

  // handshake
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;
  assign walk_end    = (CW'(cnt_q + CW'(1)) == occ_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    ptr_d        = ptr_q;
    occ_d        = occ_q;
    cnt_d        = cnt_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_raddr    = ptr_q;
    key_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        ram_raddr = head_q;
        if (accept) begin
          out_value_d = '0;
          out_last_d  = 1'b1;
          ptr_d       = head_q;
          cnt_d       = '0;
          case (in_i.operation)
            cqs_pkg::OpEnq: begin
              out_load = 1'b1;
              if (occ_q >= cap) begin
                out_status_d = cqs_pkg::StatFull;
              end else begin
                ram_we       = 1'b1;
                tail_d       = step_ptr(tail_q);
                occ_d        = occ_q + CW'(1);
                out_status_d = cqs_pkg::StatOk;
              end
            end
            cqs_pkg::OpDeq: begin
              if (occ_q == '0) begin
                out_load     = 1'b1;
                out_status_d = cqs_pkg::StatEmpty;
              end else begin
                state_d = S_DEQ;
              end
            end
            cqs_pkg::OpSrch: begin
              if (occ_q == '0) begin
                out_load     = 1'b1;
                out_status_d = cqs_pkg::StatNotFound;
              end else begin
                key_load = 1'b1;
                state_d  = S_SRCH;
              end
            end
            cqs_pkg::OpDisp: begin
              if (occ_q == '0) begin
                out_load     = 1'b1;
                out_status_d = cqs_pkg::StatEmpty;
              end else begin
                state_d = S_DISP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // head word is on the read data
      S_DEQ: begin
        out_load     = 1'b1;
        out_status_d = cqs_pkg::StatOk;
        out_value_d  = rd_data;
        out_last_d   = 1'b1;
        head_d       = step_ptr(head_q);
        occ_d        = occ_q - CW'(1);
        state_d      = S_IDLE;
      end

      // one stored word compared per cycle
      S_SRCH: begin
        if (hit || walk_end) begin
          out_load     = 1'b1;
          out_status_d = hit ? cqs_pkg::StatFound : cqs_pkg::StatNotFound;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ptr_d     = step_ptr(ptr_q);
          ram_raddr = step_ptr(ptr_q);
          cnt_d     = cnt_q + CW'(1);
        end
      end

      // one stored word emitted per cycle the receiver allows
      S_DISP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = cqs_pkg::StatOk;
          out_value_d  = rd_data;
          out_last_d   = walk_end;
          if (walk_end) begin
            state_d = S_IDLE;
          end else begin
            ptr_d     = step_ptr(ptr_q);
            ram_raddr = step_ptr(ptr_q);
            cnt_d     = cnt_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      ptr_q       <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      qsize_q     <= cqs_pkg::QsizeRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ptr_q       <= ptr_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        qsize_q <= cfg_wdata_i;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.value_res = out_value_q;
  assign out_o.last      = out_last_q;

  // entry store
  cqs_ram #(
    .Width (WW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_i.value),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // shared compare unit
  cqs_cmp u_cmp (
    .clk_i      (clk_i),
    .key_load_i (key_load),
    .key_i      (in_i.value),
    .word_i     (rd_data),
    .hit_o      (hit)
  );

  // checks
  `CQS_ASSERT_IMPL(a_empty_ptrs, clk_i, rst_ni, occ_q == '0, head_q == tail_q, "empty queue with head and tail apart")
  `CQS_ASSERT_IMPL(a_walk_cnt, clk_i, rst_ni, (state_q == S_SRCH) || (state_q == S_DISP), cnt_q < occ_q, "walk counter past occupancy")
  `CQS_ASSERT_IMPL(a_srch_out_free, clk_i, rst_ni, (state_q == S_SRCH) || (state_q == S_DEQ), !out_valid_q, "result register busy during a single-result walk")
  `CQS_ASSERT_NEXT(a_enq_count, clk_i, rst_ni, accept && (in_i.operation == cqs_pkg::OpEnq) && (occ_q < cap), occ_q == $past(occ_q) + CW'(1), "enqueue did not raise occupancy")

endmodule

`default_nettype wire
